[rtl/ezr_pkg.sv]
// ----------------------------------------------------------------------------
// ezr_pkg - shared types and constants for the Euler ZYX rotation block
// CORDIC constants, arctangent table and payload structs.
// ----------------------------------------------------------------------------
package ezr_pkg;

	localparam int CordicIterDefault = 14;
	localparam int AtanLen = 24;
	localparam int ZW = 28;   // Q.24 angle plus sign and headroom
	localparam int XW = 27;   // Q.24 x/y with headroom for gain growth
	localparam int TW = 22;   // Q.20 trig value, range +-2^20

	localparam logic signed [ZW-1:0] PiQ24 = 28'sd52707179;
	localparam logic signed [ZW-1:0] HalfPiQ24 = 28'sd26353589;
	localparam logic signed [XW-1:0] GainQ24 = 27'sd10188014;
	localparam logic signed [TW-1:0] UnityQ20 = 22'sd1048576;
	localparam logic signed [15:0] UnityQ14 = 16'sd16384;

	typedef logic signed [15:0] angle_t;
	typedef logic signed [15:0] entry_t;
	typedef logic signed [TW-1:0] trig_t;

	typedef struct packed {
		angle_t roll_angle;
		angle_t pitch_angle;
		angle_t yaw_angle;
	} angles_t;

	typedef struct packed {
		entry_t r00; entry_t r01; entry_t r02;
		entry_t r10; entry_t r11; entry_t r12;
		entry_t r20; entry_t r21; entry_t r22;
	} matrix_t;

	// Arctangent of 2^-i in Q.24
	function automatic logic signed [ZW-1:0] atan_q24(input int i);
		logic signed [ZW-1:0] t;
		case (i)
			0: t = 28'sd13176795;
			1: t = 28'sd7778716;
			2: t = 28'sd4110060;
			3: t = 28'sd2086331;
			4: t = 28'sd1047214;
			5: t = 28'sd524117;
			6: t = 28'sd262123;
			7: t = 28'sd131069;
			default: t = (i < AtanLen) ? (ZW'(1) <<< (24 - i)) : '0;
		endcase
		return t;
	endfunction

endpackage

[rtl/ezr_stream_if.sv]
// ----------------------------------------------------------------------------
// ezr_stream_if - valid/ready channel
// Carries one request of type payload_t from a source to a sink.
// ----------------------------------------------------------------------------
interface ezr_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/ezr_trig_matrix.sv]
// ----------------------------------------------------------------------------
// ezr_trig_matrix - product and rounding stages
// Forms the nine matrix entries from six Q.20 sines/cosines over three
// register stages: two-factor products, triple products, sum and saturate.
// ----------------------------------------------------------------------------
module ezr_trig_matrix (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  ezr_pkg::trig_t    sr, cr, sp, cp, sy, cy,
	output logic              out_valid,
	output ezr_pkg::matrix_t  out_mat
);
	import ezr_pkg::*;

	localparam int PW = 2 * TW;   // Q.40 two-factor product
	localparam int SW = 68;       // Q.60 sums

	logic [2:0] v_q;
	// stage a: two-factor products
	logic signed [PW-1:0] cpcy_s1, cpsy_s1, crsy_s1, srsy_s1, crcy_s1, srcy_s1;
	logic signed [PW-1:0] srcp_s1, crcp_s1, srsp_s1, crsp_s1;
	trig_t sp_s1, cy_s1, sy_s1;
	// stage b: triple products
	logic signed [SW-1:0] t01_s2, t02_s2, t11_s2, t12_s2;
	logic signed [PW-1:0] cpcy_s2, cpsy_s2, crsy_s2, srsy_s2, crcy_s2, srcy_s2;
	logic signed [PW-1:0] srcp_s2, crcp_s2;
	trig_t sp_s2;

	function automatic entry_t to_q14(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] r;
		r = (v + (SW'(1) <<< 45)) >>> 46;
		if (r > SW'(UnityQ14)) return UnityQ14;
		if (r < -SW'(UnityQ14)) return -UnityQ14;
		return entry_t'(r);
	endfunction

	function automatic logic signed [SW-1:0] up(input logic signed [PW-1:0] p);
		return SW'(p) <<< 20;
	endfunction

	// valid travels with data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[1:0], in_valid};
		end
	end
	assign out_valid = v_q[2];

	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s1 <= cp * cy; cpsy_s1 <= cp * sy;
			crsy_s1 <= cr * sy; srsy_s1 <= sr * sy;
			crcy_s1 <= cr * cy; srcy_s1 <= sr * cy;
			srcp_s1 <= sr * cp; crcp_s1 <= cr * cp;
			srsp_s1 <= sr * sp; crsp_s1 <= cr * sp;
			sp_s1 <= sp; cy_s1 <= cy; sy_s1 <= sy;

			t01_s2 <= srsp_s1 * cy_s1; t02_s2 <= crsp_s1 * cy_s1;
			t11_s2 <= srsp_s1 * sy_s1; t12_s2 <= crsp_s1 * sy_s1;
			cpcy_s2 <= cpcy_s1; cpsy_s2 <= cpsy_s1; crsy_s2 <= crsy_s1;
			srsy_s2 <= srsy_s1; crcy_s2 <= crcy_s1; srcy_s2 <= srcy_s1;
			srcp_s2 <= srcp_s1; crcp_s2 <= crcp_s1; sp_s2 <= sp_s1;

			out_mat.r00 <= to_q14(up(cpcy_s2));
			out_mat.r01 <= to_q14(t01_s2 - up(crsy_s2));
			out_mat.r02 <= to_q14(t02_s2 + up(srsy_s2));
			out_mat.r10 <= to_q14(up(cpsy_s2));
			out_mat.r11 <= to_q14(t11_s2 + up(crcy_s2));
			out_mat.r12 <= to_q14(t12_s2 - up(srcy_s2));
			out_mat.r20 <= to_q14(-(SW'(sp_s2) <<< 40));
			out_mat.r21 <= to_q14(up(srcp_s2));
			out_mat.r22 <= to_q14(up(crcp_s2));
		end
	end

endmodule

[rtl/euler_zyx_to_rotation_matrix.sv]
// ----------------------------------------------------------------------------
// euler_zyx_to_rotation_matrix - Euler ZYX angles to rotation matrix
// Pipelined CORDIC sine/cosine for three angles, then product stages.
// ----------------------------------------------------------------------------
// Usage:
//   in  : request of roll, pitch, yaw angles, signed Q3.13 radians.
//   out : request of nine row-major entries of Rz*Ry*Rx, signed Q1.14.
//   One request enters per cycle and one result leaves per cycle, unless stalled.
//   Pipeline: one fold stage, one stage per CORDIC iteration, one rounding
//   stage, three product/sum stages. A single output register holds the
//   result.
//   Throughput is one request per cycle while not stalled, set by the fully
//   unrolled CORDIC and multiplier pipeline.
//   Stall: when out.valid is high and out.ready low the whole pipeline
//   freezes; in.ready drops only then, so nothing is lost or repeated.
//   Reset clears all valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
module euler_zyx_to_rotation_matrix #(
	parameter int CORDIC_ITERATIONS = ezr_pkg::CordicIterDefault
) (
	input  logic          clk,
	input  logic          arst_n,
	ezr_stream_if.sink    in,
	ezr_stream_if.source  out
);
	import ezr_pkg::*;

	localparam int N = (CORDIC_ITERATIONS > AtanLen) ? AtanLen : CORDIC_ITERATIONS;

	logic en;
	assign en = !out.valid || out.ready;
	assign in.ready = en;

	// per-angle CORDIC pipeline: [0] roll, [1] pitch, [2] yaw
	logic signed [XW-1:0] x_q [3][N+1];
	logic signed [XW-1:0] y_q [3][N+1];
	logic signed [ZW-1:0] z_q [3][N+1];
	logic                 f_q [3][N+1];
	logic [N:0]           v_q;
	trig_t                s_q [3];
	trig_t                c_q [3];
	logic                 vt_q;
	angle_t               ang [3];

	assign ang[0] = in.data.roll_angle;
	assign ang[1] = in.data.pitch_angle;
	assign ang[2] = in.data.yaw_angle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q  <= '0;
			vt_q <= 1'b0;
		end else if (en) begin
			v_q  <= {v_q[N-1:0], in.valid};
			vt_q <= v_q[N];
		end
	end

	function automatic trig_t rnd(input logic signed [XW-1:0] v, input logic neg);
		logic signed [XW:0] t;
		logic signed [XW:0] r;
		t = neg ? -(XW+1)'(v) : (XW+1)'(v);
		r = (t + (XW+1)'(8)) >>> 4;
		if (r > (XW+1)'(UnityQ20)) return UnityQ20;
		if (r < -(XW+1)'(UnityQ20)) return -UnityQ20;
		return trig_t'(r);
	endfunction

	for (genvar a = 0; a < 3; a++) begin : g_ang
		// fold into +-pi/2
		always_ff @(posedge clk) begin
			logic signed [ZW-1:0] z;
			z = ZW'(ang[a]) <<< 11;
			if (en) begin
				x_q[a][0] <= GainQ24;
				y_q[a][0] <= '0;
				if (z > HalfPiQ24) begin
					z_q[a][0] <= z - PiQ24; f_q[a][0] <= 1'b1;
				end else if (z < -HalfPiQ24) begin
					z_q[a][0] <= z + PiQ24; f_q[a][0] <= 1'b1;
				end else begin
					z_q[a][0] <= z; f_q[a][0] <= 1'b0;
				end
			end
		end
		// one CORDIC iteration per stage
		for (genvar i = 0; i < N; i++) begin : g_it
			always_ff @(posedge clk) begin
				if (en) begin
					f_q[a][i+1] <= f_q[a][i];
					if (!z_q[a][i][ZW-1]) begin
						x_q[a][i+1] <= x_q[a][i] - (y_q[a][i] >>> i);
						y_q[a][i+1] <= y_q[a][i] + (x_q[a][i] >>> i);
						z_q[a][i+1] <= z_q[a][i] - atan_q24(i);
					end else begin
						x_q[a][i+1] <= x_q[a][i] + (y_q[a][i] >>> i);
						y_q[a][i+1] <= y_q[a][i] - (x_q[a][i] >>> i);
						z_q[a][i+1] <= z_q[a][i] + atan_q24(i);
					end
				end
			end
		end
		// round to Q.20 and clamp
		always_ff @(posedge clk) begin
			if (en) begin
				c_q[a] <= rnd(x_q[a][N], f_q[a][N]);
				s_q[a] <= rnd(y_q[a][N], f_q[a][N]);
			end
		end
	end

	ezr_trig_matrix u_mat (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vt_q),
		.sr        (s_q[0]), .cr (c_q[0]),
		.sp        (s_q[1]), .cp (c_q[1]),
		.sy        (s_q[2]), .cy (c_q[2]),
		.out_valid (out.valid),
		.out_mat   (out.data)
	);

endmodule
